/* rtl/dbsm_pkg.sv */
// dbsm_pkg: shared types, constants and helper functions for the base substitution mutator
// used by dbsm_ctrl, dbsm_datapath and the top level; depends on nothing
package dbsm_pkg;

  // generator constants
  localparam logic [63:0] GOLDEN_STEP  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL_ONE  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL_TWO  = 64'h94D049BB133111EB;
  localparam logic [63:0] SEED_BASIS   = 64'hA0761D6478BD642F;
  localparam logic [63:0] NOSEED_BASIS = 64'hE7037ED1A0B428DB;

  // field and register widths
  localparam int BYTE_W    = 8;
  localparam int THRESH_W  = 54;
  localparam int SEED_W    = 32;
  localparam int TOTAL_W   = 32;
  localparam int CFG_IDX_W = 2;

  // ascii codes of the bases
  localparam logic [BYTE_W-1:0] CHAR_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_C = 8'h43;
  localparam logic [BYTE_W-1:0] CHAR_G = 8'h47;
  localparam logic [BYTE_W-1:0] CHAR_T = 8'h54;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESH  = 2'd0,
    REG_SEED    = 2'd1,
    REG_SEED_EN = 2'd2
  } cfg_idx_t;

  // partial product selection of the shared 32x32 multiplier
  typedef enum logic [1:0] {
    MUL_LL = 2'd0,
    MUL_LH = 2'd1,
    MUL_HL = 2'd2
  } mul_step_t;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADV,
    S_M1_LL,
    S_M1_LH,
    S_M1_HL,
    S_MIX,
    S_M2_LL,
    S_M2_LH,
    S_M2_HL,
    S_FIN,
    S_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic      capture;
    logic      adv;
    logic      mul_en;
    mul_step_t mul_step;
    logic      mul_k2;
    logic      mix;
    logic      apply_sub;
    logic      load_out;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic in_is_base;
    logic below_thresh;
    logic cand_differs;
    logic out_free;
  } dp_stat_t;

  // true for A, C, G or T
  function automatic logic is_base_char(input logic [BYTE_W-1:0] b);
    return (b == CHAR_A) || (b == CHAR_C) || (b == CHAR_G) || (b == CHAR_T);
  endfunction

  // base picked by two random bits
  function automatic logic [BYTE_W-1:0] base_of(input logic [1:0] sel);
    logic [BYTE_W-1:0] r;
    case (sel)
      2'd0:    r = CHAR_A;
      2'd1:    r = CHAR_C;
      2'd2:    r = CHAR_G;
      default: r = CHAR_T;
    endcase
    return r;
  endfunction

endpackage

/* rtl/dbsm_ctrl.sv */
// dbsm_ctrl: sequencer for one item, steps the draw through the shared multiplier
// depends on dbsm_pkg
module dbsm_ctrl
  import dbsm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     cfg_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  // 0 while testing the threshold draw, 1 while drawing replacement candidates
  logic   phase_r, phase_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          phase_nxt = 1'b0;
          state_nxt = stat.in_is_base ? S_ADV : S_DONE;
        end
      end
      S_ADV:   state_nxt = S_M1_LL;
      S_M1_LL: state_nxt = S_M1_LH;
      S_M1_LH: state_nxt = S_M1_HL;
      S_M1_HL: state_nxt = S_MIX;
      S_MIX:   state_nxt = S_M2_LL;
      S_M2_LL: state_nxt = S_M2_LH;
      S_M2_LH: state_nxt = S_M2_HL;
      S_M2_HL: state_nxt = S_FIN;
      S_FIN: begin
        if (!phase_r) begin
          if (stat.below_thresh) begin
            phase_nxt = 1'b1;
            state_nxt = S_ADV;
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          state_nxt = stat.cand_differs ? S_DONE : S_ADV;
        end
      end
      S_DONE: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    cfg_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_stall    = 1'b0;
        cfg_ready   = 1'b1;
        cmd.capture = in_valid;
      end
      S_ADV: cmd.adv = 1'b1;
      S_M1_LL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MUL_LL;
      end
      S_M1_LH: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MUL_LH;
      end
      S_M1_HL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MUL_HL;
      end
      S_MIX: cmd.mix = 1'b1;
      S_M2_LL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MUL_LL;
        cmd.mul_k2   = 1'b1;
      end
      S_M2_LH: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MUL_LH;
        cmd.mul_k2   = 1'b1;
      end
      S_M2_HL: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MUL_HL;
        cmd.mul_k2   = 1'b1;
      end
      S_FIN:  cmd.apply_sub = phase_r && stat.cand_differs;
      S_DONE: cmd.load_out  = stat.out_free;
      default: ;
    endcase
  end

endmodule

/* rtl/dbsm_datapath.sv */
// dbsm_datapath: generator state, shared 32x32 multiplier, counters, config and output registers
// depends on dbsm_pkg
module dbsm_datapath
  import dbsm_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [BYTE_W-1:0]    in_byte,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THRESH_W-1:0]  cfg_wdata,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 is_base,
  output logic                 was_mutated,
  output logic [TOTAL_W-1:0]   base_total,
  output logic [TOTAL_W-1:0]   mutation_total
);

  // configuration registers
  logic [THRESH_W-1:0] thresh_r, thresh_nxt;
  logic [SEED_W-1:0]   seed_r, seed_nxt;
  logic                seed_en_r, seed_en_nxt;
  logic                cfg_hit;

  // generator and multiply registers
  logic [63:0] rng_r;
  logic [63:0] op_r;
  logic [63:0] acc_r;

  // item registers
  logic [BYTE_W-1:0]      byte_r;
  logic                   is_base_r;
  logic                   mutated_r;
  logic [COUNT_WIDTH-1:0] base_cnt_r;
  logic [COUNT_WIDTH-1:0] mut_cnt_r;

  // output registers
  logic                out_valid_r;
  logic [BYTE_W-1:0]   out_byte_r;
  logic                out_is_base_r;
  logic                out_mutated_r;
  logic [TOTAL_W-1:0]  out_base_total_r;
  logic [TOTAL_W-1:0]  out_mut_total_r;

  // config decode, the new values feed the seed reload
  always_comb begin
    thresh_nxt  = thresh_r;
    seed_nxt    = seed_r;
    seed_en_nxt = seed_en_r;
    cfg_hit     = 1'b0;
    unique case (cfg_idx_t'(cfg_index))
      REG_THRESH: begin
        thresh_nxt = cfg_wdata;
        cfg_hit    = 1'b1;
      end
      REG_SEED: begin
        seed_nxt = cfg_wdata[SEED_W-1:0];
        cfg_hit  = 1'b1;
      end
      REG_SEED_EN: begin
        seed_en_nxt = cfg_wdata[0];
        cfg_hit     = 1'b1;
      end
      default: cfg_hit = 1'b0;
    endcase
  end

  // generator advance; the first xor-shift is applied when op_r loads
  logic [63:0] rng_sum;
  assign rng_sum = rng_r + GOLDEN_STEP;

  // shared multiplier operands
  logic [63:0] mul_k;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_prod;
  assign mul_k = cmd.mul_k2 ? MIX_MUL_TWO : MIX_MUL_ONE;
  always_comb begin
    case (cmd.mul_step)
      MUL_LL: begin
        mul_a = op_r[31:0];
        mul_b = mul_k[31:0];
      end
      MUL_LH: begin
        mul_a = op_r[31:0];
        mul_b = mul_k[63:32];
      end
      MUL_HL: begin
        mul_a = op_r[63:32];
        mul_b = mul_k[31:0];
      end
      default: begin
        mul_a = op_r[31:0];
        mul_b = mul_k[31:0];
      end
    endcase
  end
  assign mul_prod = mul_a * mul_b;

  // finished draw and decisions
  logic [63:0]       draw;
  logic [BYTE_W-1:0] cand;
  assign draw = acc_r ^ (acc_r >> 31);
  assign cand = base_of(draw[1:0]);

  // config, generator and multiply datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r  <= '0;
      seed_r    <= '0;
      seed_en_r <= 1'b1;
      rng_r     <= SEED_BASIS;
    end else if (cfg_we && cfg_hit) begin
      thresh_r  <= thresh_nxt;
      seed_r    <= seed_nxt;
      seed_en_r <= seed_en_nxt;
      rng_r     <= seed_en_nxt ? (SEED_BASIS ^ {32'h0, seed_nxt}) : NOSEED_BASIS;
    end else if (cmd.adv) begin
      rng_r <= rng_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.adv) begin
      op_r <= rng_sum ^ (rng_sum >> 30);
    end else if (cmd.mix) begin
      op_r <= acc_r ^ (acc_r >> 27);
    end
    // low 64 bits of the product from three partial products
    if (cmd.mul_en) begin
      if (cmd.mul_step == MUL_LL) begin
        acc_r <= mul_prod;
      end else begin
        acc_r[63:32] <= acc_r[63:32] + mul_prod[31:0];
      end
    end
  end

  // saturating increments
  logic [COUNT_WIDTH-1:0] base_cnt_inc, mut_cnt_inc;
  assign base_cnt_inc = (base_cnt_r == {COUNT_WIDTH{1'b1}}) ? base_cnt_r
                      : base_cnt_r + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
  assign mut_cnt_inc  = (mut_cnt_r == {COUNT_WIDTH{1'b1}}) ? mut_cnt_r
                      : mut_cnt_r + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

  // item capture and substitution
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_r    <= in_byte;
      is_base_r <= is_base_char(in_byte);
      mutated_r <= 1'b0;
    end else if (cmd.apply_sub) begin
      byte_r    <= cand;
      mutated_r <= 1'b1;
    end
  end

  // counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cnt_r <= '0;
      mut_cnt_r  <= '0;
    end else begin
      if (cmd.capture && is_base_char(in_byte)) base_cnt_r <= base_cnt_inc;
      if (cmd.apply_sub) mut_cnt_r <= mut_cnt_inc;
    end
  end

  // low bits of the counters, zero-extended when narrower, as reported totals
  logic [TOTAL_W-1:0] base_low, mut_low;
  generate
    if (COUNT_WIDTH >= TOTAL_W) begin : g_wide
      assign base_low = base_cnt_r[TOTAL_W-1:0];
      assign mut_low  = mut_cnt_r[TOTAL_W-1:0];
    end else begin : g_narrow
      assign base_low = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, base_cnt_r};
      assign mut_low  = {{(TOTAL_W-COUNT_WIDTH){1'b0}}, mut_cnt_r};
    end
  endgenerate

  // output register
  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_byte_r       <= byte_r;
      out_is_base_r    <= is_base_r;
      out_mutated_r    <= mutated_r;
      out_base_total_r <= base_low;
      out_mut_total_r  <= mut_low;
    end
  end

  // status to the controller
  always_comb begin
    stat.in_is_base   = is_base_char(in_byte);
    stat.below_thresh = {1'b0, draw[63:11]} < thresh_r;
    stat.cand_differs = cand != byte_r;
    stat.out_free     = out_free;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_byte_r;
  assign is_base        = out_is_base_r;
  assign was_mutated    = out_mutated_r;
  assign base_total     = out_base_total_r;
  assign mutation_total = out_mut_total_r;

endmodule

/* rtl/dna_base_substitution_mutator.sv */
// random base substitution with a splitmix64 generator; one item at a time, one beat out each
// a non-base byte goes straight to the output register; a base takes a threshold draw and, if
// below the threshold, draws candidates until one differs from the byte (one 32x32 multiplier,
// three partial products per 64-bit multiply, two multiplies per draw); no new item until loaded
// reset (rst_n, synchronous, active low): threshold 0, seed 0, seeding on, counters 0
// a config write reloads the generator start value; counters are kept
module dna_base_substitution_mutator
  import dbsm_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [BYTE_W-1:0]    in_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_is_base,
  output logic                 out_was_mutated,
  output logic [TOTAL_W-1:0]   out_base_total,
  output logic [TOTAL_W-1:0]   out_mutation_total,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [THRESH_W-1:0]  cfg_wdata
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  dbsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  dbsm_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_byte        (in_byte),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .is_base        (out_is_base),
    .was_mutated    (out_was_mutated),
    .base_total     (out_base_total),
    .mutation_total (out_mutation_total)
  );

endmodule

/* rtl/dbsm_checker.sv */
// dbsm_checker: port-level assertions for the base substitution mutator, bound to the top
// depends on dbsm_pkg and dna_base_substitution_mutator
module dbsm_checker
  import dbsm_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [BYTE_W-1:0]   out_byte,
  input logic                out_is_base,
  input logic                out_was_mutated,
  input logic                cfg_ready
);

  // config is taken only when the input side is open
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready == !in_stall)
    else $error("cfg_ready and in_stall disagree");

  // an accepted beat closes the input side in the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while an item is in work");

  // a mutated result is a base and carries a base
  a_mut_is_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_was_mutated) |-> (out_is_base &&
      ((out_byte == CHAR_A) || (out_byte == CHAR_C) ||
       (out_byte == CHAR_G) || (out_byte == CHAR_T))))
    else $error("mutated result without a base");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte)))
    else $error("stalled result changed");

endmodule

bind dna_base_substitution_mutator dbsm_checker u_dbsm_checker (.*);
